>>> design/nsr_pkg.sv
// shared widths, register indexes and divider types for the newton square root block
package nsr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned RootW = DataW - 1;
  localparam int unsigned SqW   = 2 * RootW - FracBits;
  localparam int unsigned ErrW  = SqW + 2;
  localparam int unsigned MagW  = ErrW - 1 + FracBits;
  localparam int unsigned DivW  = RootW + 1;
  localparam int unsigned StepW = MagW + 1;
  localparam int unsigned CntW  = $clog2(MagW);

  localparam logic [CfgIdxW-1:0] RegTolerance  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegIterLimit  = CfgIdxW'(1);

  localparam logic [DataW-1:0]  ToleranceRst  = DataW'(1);
  localparam logic [LimitW-1:0] IterLimitRst  = LimitW'(32);

  typedef struct packed {
    logic             start;
    logic [MagW-1:0]  dividend;
    logic [DivW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MagW-1:0]  quotient;
  } div_rsp_t;

endpackage

>>> design/nsr_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module nsr_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nsr_pkg::div_req_t  req_i,
  output nsr_pkg::div_rsp_t  rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [nsr_pkg::CntW-1:0]    count_q, count_d;
  logic [nsr_pkg::DivW-1:0]    rem_q, rem_d;
  logic [nsr_pkg::MagW-1:0]    quo_q, quo_d;
  logic [nsr_pkg::DivW-1:0]    dsr_q, dsr_d;
  logic [nsr_pkg::DivW:0]      trial;
  logic [nsr_pkg::DivW+1:0]    diff;

  assign trial = {rem_q, quo_q[nsr_pkg::MagW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    count_d = count_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      count_d = '0;
      rem_d   = '0;
      quo_d   = req_i.dividend;
      dsr_d   = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[nsr_pkg::DivW+1]) begin
        rem_d = diff[nsr_pkg::DivW-1:0];
        quo_d = {quo_q[nsr_pkg::MagW-2:0], 1'b1};
      end else begin
        rem_d = trial[nsr_pkg::DivW-1:0];
        quo_d = {quo_q[nsr_pkg::MagW-2:0], 1'b0};
      end
      count_d = count_q + nsr_pkg::CntW'(1);
      if (count_q == nsr_pkg::CntW'(nsr_pkg::MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> design/newton_square_root.sv
// newton square root top level: sequencer, multiplier, root update and divider
//
// usage notes
// - input word: square_value_i (signed q16.16), taken when start is high and busy is low
// - result word: root_value_o, negative_input_o, steps_used_o, converged_o, valid for
//   exactly one cycle while done_o is high; the receiver cannot stall it
// - configuration: cfg_we_i with cfg_index_i (0 tolerance, 1 iteration limit) and
//   cfg_wdata_i; write only while busy is low, which the block itself does not enforce
// - a negative or zero input gives its result in the cycle after acceptance, busy stays low
// - otherwise busy is high from the cycle after acceptance until the result shows
// - each newton step runs through StMul (square), StCheck (check) and StDiv, which waits
//   on the divider (one quotient bit per cycle over 63 bits, then hand-back)
// - the number of steps is at most the iteration limit
// - reset sets tolerance to 1, the limit to 32 and leaves the block idle
// - one word is in flight at a time; the next may start in the cycle done_o shows
module newton_square_root (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [nsr_pkg::DataW-1:0]  square_value_i,
  input  logic                              cfg_we_i,
  input  logic [nsr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [nsr_pkg::DataW-1:0]         cfg_wdata_i,
  output logic                              done_o,
  output logic signed [nsr_pkg::DataW-1:0]  root_value_o,
  output logic                              negative_input_o,
  output logic [nsr_pkg::LimitW-1:0]        steps_used_o,
  output logic                              converged_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMul   = 2'd1;
  localparam logic [1:0] StCheck = 2'd2;
  localparam logic [1:0] StDiv   = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [nsr_pkg::DataW-1:0]     tol_q;
  logic [nsr_pkg::LimitW-1:0]    limit_q;
  logic [nsr_pkg::DataW-1:0]     value_q, value_d;
  logic [nsr_pkg::RootW-1:0]     root_q, root_d;
  logic [nsr_pkg::ErrW-1:0]      err_q, err_d;
  logic [nsr_pkg::LimitW-1:0]    steps_q, steps_d;

  logic                          done_q, done_d;
  logic [nsr_pkg::DataW-1:0]     res_root_q, res_root_d;
  logic                          res_neg_q, res_neg_d;
  logic [nsr_pkg::LimitW-1:0]    res_steps_q, res_steps_d;
  logic                          res_conv_q, res_conv_d;

  logic [2*nsr_pkg::RootW-1:0]   prod;
  logic [nsr_pkg::SqW-1:0]       sq;
  logic [nsr_pkg::ErrW-1:0]      err_mag;
  logic                          within_tol;
  logic [nsr_pkg::StepW-1:0]     step;
  logic [nsr_pkg::StepW-1:0]     root_new;
  logic [nsr_pkg::RootW-1:0]     root_clamped;

  nsr_pkg::div_req_t             div_req;
  nsr_pkg::div_rsp_t             div_rsp;

  nsr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // square and error
  assign prod  = root_q * root_q;
  assign sq    = prod[2*nsr_pkg::RootW-1:nsr_pkg::FracBits];
  assign err_d = {2'b00, sq}
               - {{(nsr_pkg::ErrW - nsr_pkg::DataW){value_q[nsr_pkg::DataW-1]}}, value_q};

  assign err_mag    = err_q[nsr_pkg::ErrW-1] ? (~err_q + nsr_pkg::ErrW'(1)) : err_q;
  assign within_tol = err_mag <= {{(nsr_pkg::ErrW - nsr_pkg::DataW){1'b0}}, tol_q};

  // root update with clamp to [1, max]
  assign step = err_q[nsr_pkg::ErrW-1] ? (~{1'b0, div_rsp.quotient} + nsr_pkg::StepW'(1))
                                       : {1'b0, div_rsp.quotient};
  assign root_new = {{(nsr_pkg::StepW - nsr_pkg::RootW){1'b0}}, root_q} - step;

  always_comb begin
    if (root_new[nsr_pkg::StepW-1] || (root_new == '0)) begin
      root_clamped = nsr_pkg::RootW'(1);
    end else if (|root_new[nsr_pkg::StepW-2:nsr_pkg::RootW]) begin
      root_clamped = '1;
    end else begin
      root_clamped = root_new[nsr_pkg::RootW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    root_d      = root_q;
    steps_d     = steps_q;
    done_d      = 1'b0;
    res_root_d  = res_root_q;
    res_neg_d   = res_neg_q;
    res_steps_d = res_steps_q;
    res_conv_d  = res_conv_q;
    div_req.start    = 1'b0;
    div_req.dividend = {err_mag[nsr_pkg::ErrW-2:0], {nsr_pkg::FracBits{1'b0}}};
    div_req.divisor  = {root_q, 1'b0};
    unique case (state_q)
      StIdle: begin
        if (start) begin
          value_d = square_value_i;
          root_d  = square_value_i[nsr_pkg::RootW-1:0];
          steps_d = '0;
          if (square_value_i[nsr_pkg::DataW-1]) begin
            done_d      = 1'b1;
            res_root_d  = ~nsr_pkg::DataW'((1 << nsr_pkg::FracBits) - 1);
            res_neg_d   = 1'b1;
            res_steps_d = '0;
            res_conv_d  = 1'b0;
          end else if (square_value_i == '0) begin
            done_d      = 1'b1;
            res_root_d  = '0;
            res_neg_d   = 1'b0;
            res_steps_d = '0;
            res_conv_d  = 1'b1;
          end else begin
            state_d = StMul;
          end
        end
      end
      StMul: begin
        state_d = StCheck;
      end
      StCheck: begin
        if ((steps_q < limit_q) && !within_tol) begin
          div_req.start = 1'b1;
          state_d       = StDiv;
        end else begin
          done_d      = 1'b1;
          res_root_d  = {1'b0, root_q};
          res_neg_d   = 1'b0;
          res_steps_d = steps_q;
          res_conv_d  = within_tol;
          state_d     = StIdle;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          root_d  = root_clamped;
          steps_d = steps_q + nsr_pkg::LimitW'(1);
          state_d = StMul;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      tol_q   <= nsr_pkg::ToleranceRst;
      limit_q <= nsr_pkg::IterLimitRst;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          nsr_pkg::RegTolerance: tol_q   <= cfg_wdata_i;
          nsr_pkg::RegIterLimit: limit_q <= cfg_wdata_i[nsr_pkg::LimitW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    root_q      <= root_d;
    steps_q     <= steps_d;
    res_root_q  <= res_root_d;
    res_neg_q   <= res_neg_d;
    res_steps_q <= res_steps_d;
    res_conv_q  <= res_conv_d;
    if (state_q == StMul) begin
      err_q <= err_d;
    end
  end

  assign busy             = (state_q != StIdle);
  assign done_o           = done_q;
  assign root_value_o     = res_root_q;
  assign negative_input_o = res_neg_q;
  assign steps_used_o     = res_steps_q;
  assign converged_o      = res_conv_q;

endmodule
